// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the lock manager RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define FLM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every clock edge, reset included.
`define FLM_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/core/flm_pkg.sv =====
// Types and constants of the FIFO handoff lock manager.
package flm_pkg;

  localparam int MAX_WAITERS = 16;
  localparam int ID_BITS     = 8;
  localparam int CNT_W       = $clog2(MAX_WAITERS + 1);
  localparam int IDX_W       = (MAX_WAITERS > 1) ? $clog2(MAX_WAITERS) : 1;
  localparam int PORT_ID_W   = 8;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 24;

  typedef logic [ID_BITS-1:0] id_t;
  typedef logic [CNT_W-1:0]   cnt_t;
  typedef logic [IDX_W-1:0]   idx_t;

  typedef enum logic [1:0] {
    OP_LOCK    = 2'd0,
    OP_TRYLOCK = 2'd1,
    OP_UNLOCK  = 2'd2,
    OP_SIGNAL  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_ACQUIRED    = 3'd0,
    ST_QUEUED      = 3'd1,
    ST_BUSY        = 3'd2,
    ST_FULL        = 3'd3,
    ST_RELEASED    = 3'd4,
    ST_CANCELLED   = 3'd5,
    ST_NOT_WAITING = 3'd6
  } status_t;

  typedef struct packed {
    op_t  op;
    id_t  id;
    logic intr;
  } req_t;

  typedef struct packed {
    status_t status;
    logic    grant_valid;
    id_t     grant_id;
    logic    locked;
    id_t     owner_now;
  } rsp_t;

  // queue command: query id drives the match, push/drop act at the clock edge
  typedef struct packed {
    id_t  query_id;
    logic push;
    logic push_intr;
    logic drop;
    idx_t drop_pos;
  } qcmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    id_t  head_id;
    logic hit;
    idx_t hit_pos;
  } qstat_t;

endpackage

// ===== rtl/core/flm_queue.sv =====
// Waiter queue: FIFO of ids with parallel match and compaction.
`include "assert_macros.svh"

module flm_queue
  import flm_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  qcmd_t  cmd,
  output qstat_t stat
);

  id_t  ids_r  [MAX_WAITERS];
  logic intr_r [MAX_WAITERS];
  cnt_t count_r, count_nxt;
  logic [MAX_WAITERS-1:0] hit_vec;
  idx_t hit_pos;

  always_comb begin
    for (int k = 0; k < MAX_WAITERS; k++) begin
      hit_vec[k] = (CNT_W'(k) < count_r) && (ids_r[k] == cmd.query_id) && intr_r[k];
    end
  end

  always_comb begin
    hit_pos = '0;
    for (int k = MAX_WAITERS - 1; k >= 0; k--) begin
      if (hit_vec[k]) begin
        hit_pos = IDX_W'(k);
      end
    end
  end

  assign stat.empty   = (count_r == '0);
  assign stat.full    = (count_r == CNT_W'(MAX_WAITERS));
  assign stat.head_id = ids_r[0];
  assign stat.hit     = |hit_vec;
  assign stat.hit_pos = hit_pos;

  always_comb begin
    count_nxt = count_r;
    if (cmd.push && !stat.full) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (cmd.drop && !stat.empty) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push && !stat.full) begin
      ids_r[count_r[IDX_W-1:0]]  <= cmd.query_id;
      intr_r[count_r[IDX_W-1:0]] <= cmd.push_intr;
    end else if (cmd.drop) begin
      for (int k = 0; k < MAX_WAITERS - 1; k++) begin
        if (IDX_W'(k) >= cmd.drop_pos) begin
          ids_r[k]  <= ids_r[k+1];
          intr_r[k] <= intr_r[k+1];
        end
      end
    end
  end

  `FLM_ASSERT(a_count_bound, count_r <= CNT_W'(MAX_WAITERS), "waiter count over depth")
  `FLM_ASSERT(a_push_grows, (cmd.push && !stat.full) |=> count_r == $past(count_nxt), "push lost")
  `FLM_ASSERT(a_drop_shrinks, (cmd.drop && !stat.empty) |=> count_r < $past(count_r), "drop lost")

endmodule

// ===== rtl/core/flm_ctrl.sv =====
// Lock decision logic and owner registers.
`include "assert_macros.svh"

module flm_ctrl
  import flm_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   fire,
  input  req_t   req,
  input  qstat_t qstat,
  output qcmd_t  qcmd,
  output rsp_t   rsp
);

  logic owner_valid_r, owner_valid_nxt;
  id_t  owner_id_r, owner_id_nxt;
  logic push, drop, grant;
  idx_t drop_pos;
  status_t status;

  always_comb begin
    owner_valid_nxt = owner_valid_r;
    owner_id_nxt    = owner_id_r;
    push     = 1'b0;
    drop     = 1'b0;
    drop_pos = '0;
    grant    = 1'b0;
    status   = ST_NOT_WAITING;
    case (req.op)
      OP_LOCK: begin
        if (!owner_valid_r) begin
          owner_valid_nxt = 1'b1;
          owner_id_nxt    = req.id;
          status          = ST_ACQUIRED;
        end else if (qstat.full) begin
          status = ST_FULL;
        end else begin
          push   = 1'b1;
          status = ST_QUEUED;
        end
      end
      OP_TRYLOCK: begin
        if (!owner_valid_r) begin
          owner_valid_nxt = 1'b1;
          owner_id_nxt    = req.id;
          status          = ST_ACQUIRED;
        end else begin
          status = ST_BUSY;
        end
      end
      OP_UNLOCK: begin
        if (owner_valid_r && !qstat.empty) begin
          owner_id_nxt = qstat.head_id;
          grant        = 1'b1;
          drop         = 1'b1;
        end else begin
          owner_valid_nxt = 1'b0;
          owner_id_nxt    = '0;
        end
        status = ST_RELEASED;
      end
      OP_SIGNAL: begin
        if (qstat.hit) begin
          drop     = 1'b1;
          drop_pos = qstat.hit_pos;
          status   = ST_CANCELLED;
        end
      end
      default: begin
        status = ST_NOT_WAITING;
      end
    endcase
  end

  assign qcmd.query_id  = req.id;
  assign qcmd.push      = fire && push;
  assign qcmd.push_intr = req.intr;
  assign qcmd.drop      = fire && drop;
  assign qcmd.drop_pos  = drop_pos;

  assign rsp.status      = status;
  assign rsp.grant_valid = grant;
  assign rsp.grant_id    = grant ? qstat.head_id : '0;
  assign rsp.locked      = owner_valid_nxt;
  assign rsp.owner_now   = owner_valid_nxt ? owner_id_nxt : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owner_valid_r <= 1'b0;
      owner_id_r    <= '0;
    end else if (fire) begin
      owner_valid_r <= owner_valid_nxt;
      owner_id_r    <= owner_id_nxt;
    end
  end

  `FLM_ASSERT(a_free_means_empty, !owner_valid_r |-> qstat.empty, "waiters on a free lock")
  `FLM_ASSERT(a_grant_keeps_lock, (fire && grant) |=> owner_valid_r, "handoff dropped the lock")
  `FLM_ASSERT(a_no_push_and_drop, !(qcmd.push && qcmd.drop), "push and drop together")

endmodule

// ===== rtl/core/fifo_handoff_lock_manager.sv =====
// Top level of the FIFO handoff lock manager.
//
//   channel  ports                         tdata fields (low bit up)
//   input    in_tvalid/in_tready/in_tdata  operation, requester_id, interruptible
//   output   out_tvalid/out_tready/out_tdata status, grant_valid, grant_id,
//                                          locked, owner_now
//
// One transaction per cycle sustained while the output is not stalled; a request passes
// from input to result through the input register, then decision logic into the result register.
// The owner registers and waiter queue update in the same edge that loads
// the result, so the next request sees the new state.
// Synchronous active-low reset frees the lock and empties the queue.
// A stalled result holds the input register; ready falls once both are full.
module fifo_handoff_lock_manager
  import flm_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // operation[1:0], requester_id[9:2], interruptible[10]
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata   // status[2:0], grant_valid[3], grant_id[11:4],
                                             // locked[12], owner_now[20:13]
);

  logic   in_v_r;
  req_t   req_r;
  logic   out_v_r;
  rsp_t   rsp_r;
  rsp_t   rsp;
  qcmd_t  qcmd;
  qstat_t qstat;
  logic   fire;

  assign fire      = in_v_r && (!out_v_r || out_tready);
  assign in_tready = !in_v_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_tready) begin
        in_v_r <= in_tvalid;
      end
      if (fire) begin
        out_v_r <= 1'b1;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      req_r.op   <= op_t'(in_tdata[1:0]);
      req_r.id   <= in_tdata[2 +: ID_BITS];
      req_r.intr <= in_tdata[10];
    end
    if (fire) begin
      rsp_r <= rsp;
    end
  end

  flm_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .req   (req_r),
    .qstat (qstat),
    .qcmd  (qcmd),
    .rsp   (rsp)
  );

  flm_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (qcmd),
    .stat  (qstat)
  );

  assign out_tvalid = out_v_r;
  assign out_tdata  = {3'b000,
                       PORT_ID_W'(rsp_r.owner_now),
                       rsp_r.locked,
                       PORT_ID_W'(rsp_r.grant_id),
                       rsp_r.grant_valid,
                       rsp_r.status};

endmodule
